[sv/range_add_range_max_tree_defines.svh]
// assertion macros for the range add / range max tree
`ifndef RANGE_ADD_RANGE_MAX_TREE_DEFINES_SVH
`define RANGE_ADD_RANGE_MAX_TREE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RARMT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define RARMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/rarmt_pkg.sv]
// shared constants for the range add / range max tree
package rarmt_pkg;

  // field widths fixed by the stream format
  localparam int POS_FIELD_W  = 11;
  localparam int DATA_FIELD_W = 48;

  // walk sequencer codes
  localparam int STATE_W = 4;
  localparam logic [STATE_W-1:0] ST_IDLE  = 4'd0;
  localparam logic [STATE_W-1:0] ST_VISIT = 4'd1;
  localparam logic [STATE_W-1:0] ST_RD    = 4'd2;
  localparam logic [STATE_W-1:0] ST_PL    = 4'd3;
  localparam logic [STATE_W-1:0] ST_PLW   = 4'd4;
  localparam logic [STATE_W-1:0] ST_UPD   = 4'd6;
  localparam logic [STATE_W-1:0] ST_POST1 = 4'd7;
  localparam logic [STATE_W-1:0] ST_POST2 = 4'd8;
  localparam logic [STATE_W-1:0] ST_NEXT  = 4'd9;
  localparam logic [STATE_W-1:0] ST_DONE  = 4'd10;

  // status from the node store
  typedef struct packed {
    logic clearing;
  } store_status_t;

endpackage

[sv/rarmt_store.sv]
// node store: one read port, one write port, zero sweep after reset
module rarmt_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 96
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [AW-1:0]          rd_addr,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  logic [DW-1:0]          wr_data,
  output logic [DW-1:0]          rd_data,
  output rarmt_pkg::store_status_t status
);

  logic [DW-1:0] mem [DEPTH];
  logic          clr_r;
  logic [AW-1:0] clr_cnt_r;

  // clearing sweep, one entry per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == AW'(DEPTH - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  // memory array
  always_ff @(posedge clk) begin
    if (clr_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  assign status.clearing = clr_r;

endmodule

[sv/range_add_range_max_tree.sv]
// top level: lazy segment tree with range add and range max requests
//
// Requests enter on the in_ stream: in_tuser is the request kind (0 add,
// 1 max), in_tdata carries the range and the add amount. Add requests give
// no result; each max request gives one result on the out_ stream, with
// the maximum in out_tdata and the empty-range flag in out_tuser.
// cfg_data sets the number of positions; write it only while idle.
// One request at a time walks the tree with an explicit stack; every visit
// of a node that meets the range is a read-modify-write of the node store
// (one read and one write port, registered read). A pending add is first
// pushed into both children, and after an add each partly covered node is
// refreshed from its two children. An empty range skips the walk.
// After reset the store is swept to zero, one entry per cycle, over all
// 4 * MAX_POSITIONS entries; in_tready stays low meanwhile, cfg writes are
// taken. A max result waits in the output register while out_tready is
// low; the walk of the next request may already run, but it cannot finish
// its own result until the register is free.
`include "range_add_range_max_tree_defines.svh"

module range_add_range_max_tree #(
  parameter int MAX_POSITIONS = 1024,
  parameter int VALUE_WIDTH   = 48
) (
  input  logic        clk,
  input  logic        rst_n,
  // request stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,  // range_first[10:0], range_last[21:11], add_value[69:22]
  input  logic        in_tuser,  // req_type
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata, // max_value[47:0]
  output logic        out_tuser, // empty_range
  // size register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data
);

  localparam int W     = VALUE_WIDTH;
  localparam int PFW   = rarmt_pkg::POS_FIELD_W;
  localparam int DFW   = rarmt_pkg::DATA_FIELD_W;
  localparam int PW    = $clog2(MAX_POSITIONS + 1);
  localparam int CW    = (PW > PFW) ? PW : PFW;
  localparam int DEPTH = 4 * MAX_POSITIONS;
  localparam int IW    = $clog2(DEPTH);
  localparam int SD    = 2 * (PW + 1);
  localparam int SIW   = $clog2(SD);
  localparam int SPW   = $clog2(SD + 1);
  localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic          post;
    logic [IW-1:0] idx;
    logic [PW-1:0] lo;
    logic [PW-1:0] hi;
  } frame_t;

  // saturating add at the value width
  function automatic logic [W-1:0] sat_add(input logic [W-1:0] x, input logic [W-1:0] y);
    logic [W:0] s;
    s = {x[W-1], x} + {y[W-1], y};
    if (s[W] != s[W-1]) begin
      return s[W] ? VMIN : VMAX;
    end
    return s[W-1:0];
  endfunction

  // signed max
  function automatic logic [W-1:0] smax(input logic [W-1:0] x, input logic [W-1:0] y);
    return ($signed(x) > $signed(y)) ? x : y;
  endfunction

  // field value clamped into the value width
  function automatic logic [W-1:0] sat_in(input logic [DFW-1:0] x);
    logic signed [64:0] xe;
    logic signed [64:0] hi_e;
    logic signed [64:0] lo_e;
    xe   = 65'($signed(x));
    hi_e = 65'($signed(VMAX));
    lo_e = 65'($signed(VMIN));
    if (xe > hi_e) begin
      return VMAX;
    end
    if (xe < lo_e) begin
      return VMIN;
    end
    return W'(xe);
  endfunction

  logic [rarmt_pkg::STATE_W-1:0] state_r, state_nxt;
  logic [PFW-1:0] size_r;
  logic           is_max_r, is_max_nxt;
  logic [CW-1:0]  a_r, a_nxt, b_r, b_nxt;
  logic [W-1:0]   v_r, v_nxt;
  logic [W-1:0]   acc_r, acc_nxt;
  logic           empty_r, empty_nxt;
  frame_t         cur_r, cur_nxt;
  logic [W-1:0]   nmax_r, nmax_nxt, npend_r, npend_nxt, lmax_r, lmax_nxt;
  frame_t         stk_r [SD];
  logic [SPW-1:0] sp_r, sp_nxt;
  logic           push_a_en, push_b_en;
  frame_t         push_a, push_b;
  logic           out_valid_r;
  logic [DFW-1:0] out_data_r;
  logic           out_empty_r;
  logic           out_load;

  logic [IW-1:0]  mem_ra, mem_wa;
  logic           mem_we;
  logic [2*W-1:0] mem_wd, mem_rd;
  rarmt_pkg::store_status_t st_status;

  logic [W-1:0]   rd_max, rd_pend;
  logic [IW-1:0]  lidx, ridx;
  logic [PW:0]    lohi_sum;
  logic [PW-1:0]  mid;
  logic [CW-1:0]  lo_c, hi_c;
  logic           disjoint, covered;
  logic [CW-1:0]  n_c, fa_c, fb_c, ca_c, cb_c;
  logic           in_acc;

  rarmt_store #(
    .DEPTH (DEPTH),
    .AW    (IW),
    .DW    (2 * W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (mem_ra),
    .wr_en   (mem_we),
    .wr_addr (mem_wa),
    .wr_data (mem_wd),
    .rd_data (mem_rd),
    .status  (st_status)
  );

  // handshakes
  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == rarmt_pkg::ST_IDLE) && !st_status.clearing;
  assign in_acc    = in_tvalid && in_tready;

  // node geometry
  assign rd_max   = mem_rd[2*W-1:W];
  assign rd_pend  = mem_rd[W-1:0];
  assign lidx     = {cur_r.idx[IW-2:0], 1'b0};
  assign ridx     = {cur_r.idx[IW-2:0], 1'b1};
  assign lohi_sum = {1'b0, cur_r.lo} + {1'b0, cur_r.hi};
  assign mid      = lohi_sum[PW:1];
  assign lo_c     = CW'(cur_r.lo);
  assign hi_c     = CW'(cur_r.hi);
  assign disjoint = (b_r < lo_c) || (a_r > hi_c);
  assign covered  = (a_r <= lo_c) && (hi_c <= b_r);

  // range clipping against the active size
  always_comb begin
    n_c = CW'(size_r);
    if (size_r == '0) begin
      n_c = CW'(1);
    end else if (CW'(size_r) > CW'(MAX_POSITIONS)) begin
      n_c = CW'(MAX_POSITIONS);
    end
    fa_c = CW'(in_tdata[PFW-1:0]);
    fb_c = CW'(in_tdata[2*PFW-1:PFW]);
    ca_c = (fa_c == '0) ? CW'(1) : fa_c;
    cb_c = (fb_c > n_c) ? n_c : fb_c;
  end

  // walk sequencer
  always_comb begin
    state_nxt  = state_r;
    is_max_nxt = is_max_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    v_nxt      = v_r;
    acc_nxt    = acc_r;
    empty_nxt  = empty_r;
    cur_nxt    = cur_r;
    nmax_nxt   = nmax_r;
    npend_nxt  = npend_r;
    lmax_nxt   = lmax_r;
    sp_nxt     = sp_r;
    push_a_en  = 1'b0;
    push_b_en  = 1'b0;
    push_a     = cur_r;
    push_b     = cur_r;
    mem_ra     = cur_r.idx;
    mem_we     = 1'b0;
    mem_wa     = cur_r.idx;
    mem_wd     = '0;
    out_load   = 1'b0;
    unique case (state_r)
      rarmt_pkg::ST_IDLE: begin
        if (in_acc) begin
          is_max_nxt = in_tuser;
          a_nxt      = ca_c;
          b_nxt      = cb_c;
          v_nxt      = sat_in(in_tdata[2*PFW+DFW-1:2*PFW]);
          acc_nxt    = VMIN;
          empty_nxt  = ca_c > cb_c;
          cur_nxt.post = 1'b0;
          cur_nxt.idx  = IW'(1);
          cur_nxt.lo   = PW'(1);
          cur_nxt.hi   = PW'(n_c);
          if (ca_c > cb_c) begin
            state_nxt = in_tuser ? rarmt_pkg::ST_DONE : rarmt_pkg::ST_IDLE;
          end else begin
            state_nxt = rarmt_pkg::ST_VISIT;
          end
        end
      end
      rarmt_pkg::ST_VISIT: begin
        if (cur_r.post) begin
          mem_ra    = lidx;
          state_nxt = rarmt_pkg::ST_POST1;
        end else if (disjoint) begin
          state_nxt = rarmt_pkg::ST_NEXT;
        end else begin
          state_nxt = rarmt_pkg::ST_RD;
        end
      end
      rarmt_pkg::ST_RD: begin
        nmax_nxt  = rd_max;
        npend_nxt = rd_pend;
        if ((rd_pend != '0) && (cur_r.lo != cur_r.hi)) begin
          mem_ra    = lidx;
          state_nxt = rarmt_pkg::ST_PL;
        end else begin
          state_nxt = rarmt_pkg::ST_UPD;
        end
      end
      rarmt_pkg::ST_PL: begin
        // push the pending add into the left child, fetch the right one
        mem_we    = 1'b1;
        mem_wa    = lidx;
        mem_wd    = {sat_add(rd_max, npend_r), sat_add(rd_pend, npend_r)};
        mem_ra    = ridx;
        state_nxt = rarmt_pkg::ST_PLW;
      end
      rarmt_pkg::ST_PLW: begin
        // and into the right child
        mem_we    = 1'b1;
        mem_wa    = ridx;
        mem_wd    = {sat_add(rd_max, npend_r), sat_add(rd_pend, npend_r)};
        state_nxt = rarmt_pkg::ST_UPD;
      end
      rarmt_pkg::ST_UPD: begin
        mem_we = 1'b1;
        mem_wd = {nmax_r, {W{1'b0}}};
        if (covered) begin
          if (is_max_r) begin
            acc_nxt = smax(acc_r, nmax_r);
          end else begin
            mem_wd = {sat_add(nmax_r, v_r), v_r};
          end
          state_nxt = rarmt_pkg::ST_NEXT;
        end else begin
          // defer the right child (and the refresh after an add)
          if (is_max_r) begin
            push_a_en = 1'b1;
            push_a    = '{post: 1'b0, idx: ridx, lo: PW'(mid + 1'b1), hi: cur_r.hi};
            sp_nxt    = sp_r + 1'b1;
          end else begin
            push_a_en = 1'b1;
            push_a    = '{post: 1'b1, idx: cur_r.idx, lo: cur_r.lo, hi: cur_r.hi};
            push_b_en = 1'b1;
            push_b    = '{post: 1'b0, idx: ridx, lo: PW'(mid + 1'b1), hi: cur_r.hi};
            sp_nxt    = sp_r + 2'd2;
          end
          cur_nxt   = '{post: 1'b0, idx: lidx, lo: cur_r.lo, hi: mid};
          state_nxt = rarmt_pkg::ST_VISIT;
        end
      end
      rarmt_pkg::ST_POST1: begin
        mem_ra    = ridx;
        lmax_nxt  = rd_max;
        state_nxt = rarmt_pkg::ST_POST2;
      end
      rarmt_pkg::ST_POST2: begin
        // parent max from both children
        mem_we    = 1'b1;
        mem_wd    = {smax(lmax_r, rd_max), {W{1'b0}}};
        state_nxt = rarmt_pkg::ST_NEXT;
      end
      rarmt_pkg::ST_NEXT: begin
        if (sp_r == '0) begin
          state_nxt = is_max_r ? rarmt_pkg::ST_DONE : rarmt_pkg::ST_IDLE;
        end else begin
          cur_nxt   = stk_r[SIW'(sp_r - 1'b1)];
          sp_nxt    = sp_r - 1'b1;
          state_nxt = rarmt_pkg::ST_VISIT;
        end
      end
      rarmt_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = rarmt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rarmt_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rarmt_pkg::ST_IDLE;
      sp_r        <= '0;
      size_r      <= PFW'(1024);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sp_r    <= sp_nxt;
      if (cfg_valid && cfg_ready) begin
        size_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    is_max_r <= is_max_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    v_r      <= v_nxt;
    acc_r    <= acc_nxt;
    empty_r  <= empty_nxt;
    cur_r    <= cur_nxt;
    nmax_r   <= nmax_nxt;
    npend_r  <= npend_nxt;
    lmax_r   <= lmax_nxt;
    if (push_a_en) begin
      stk_r[SIW'(sp_r)] <= push_a;
    end
    if (push_b_en) begin
      stk_r[SIW'(sp_r + 1'b1)] <= push_b;
    end
    if (out_load) begin
      out_data_r  <= DFW'($signed(acc_r));
      out_empty_r <= empty_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_empty_r;

  // checks
  `RARMT_ASSERT_NOW(a_accept_idle, in_acc, sp_r == '0, "request taken with a live stack")
  `RARMT_ASSERT_NOW(a_stack_bound, 1'b1, sp_r <= SPW'(SD), "walk stack overflow")
  `RARMT_ASSERT_NOW(a_clear_block, st_status.clearing, !in_tready, "request during clear")
  `RARMT_ASSERT_NEXT(a_done_load, (state_r == rarmt_pkg::ST_DONE) && (!out_valid_r || out_tready),
    out_valid_r, "finished max request not presented")

endmodule
